### rtl/counting_semaphore_table_core_macros.svh
// assertion helpers used by counting_semaphore_table_core.sv
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH

// same-cycle implication, off while reset is low
`define CSEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define CSEM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/csem_pkg.sv
`default_nettype none

package csem_pkg;

    localparam int SLOTS      = 16;
    localparam int WAIT_DEPTH = 16;
    localparam int KEY_BITS   = 64;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int HEAD_W = $clog2(WAIT_DEPTH);
    localparam int FILL_W = $clog2(WAIT_DEPTH + 1);

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int SEM_W  = 4;
    localparam int NAME_W = 64;
    localparam int PID_W  = 8;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 16;

    localparam int IN_DATA_W  = ((SEM_W + NAME_W + PID_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SEM_W + CNT_W + PID_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_OPEN = 2'd0;
    localparam t_cmd CMD_WAIT = 2'd1;
    localparam t_cmd CMD_POST = 2'd2;
    localparam t_cmd CMD_READ = 2'd3;

    typedef logic [ST_W-1:0] t_status;
    localparam t_status ST_OK     = 3'd0;
    localparam t_status ST_BLOCK  = 3'd1;
    localparam t_status ST_WOKEN  = 3'd2;
    localparam t_status ST_TFULL  = 3'd3;
    localparam t_status ST_QFULL  = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [HEAD_W-1:0] head;
        logic [FILL_W-1:0] fill;
    } t_slot_rec;

    typedef struct packed {
        logic                we;
        logic [SLOT_W-1:0]   idx;
        logic [KEY_BITS-1:0] key;
    } t_key_wr;

endpackage

`default_nettype wire

### rtl/csem_key_table.sv
`default_nettype none

module csem_key_table (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire csem_pkg::t_key_wr         i_wr,
    input  wire [csem_pkg::KEY_BITS-1:0]   i_key,
    output logic [csem_pkg::SLOTS-1:0]     o_used,
    output logic [csem_pkg::SLOTS-1:0]     o_match
);
    import csem_pkg::*;

    logic [SLOTS-1:0]    r_used;
    logic [KEY_BITS-1:0] r_key [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.we) begin
            r_used[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_key[i_wr.idx] <= i_wr.key;
        end
    end

    // one comparator per slot, all in parallel
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            o_match[i] = r_used[i] && (r_key[i] == i_key);
        end
    end

    assign o_used = r_used;

endmodule

`default_nettype wire

### rtl/csem_slot_mem.sv
`default_nettype none

module csem_slot_mem (
    input  wire                          i_clk,
    input  wire                          i_rd_en,
    input  wire [csem_pkg::SLOT_W-1:0]   i_rd_idx,
    output csem_pkg::t_slot_rec          o_rd_data,
    input  wire                          i_wr_en,
    input  wire [csem_pkg::SLOT_W-1:0]   i_wr_idx,
    input  wire csem_pkg::t_slot_rec     i_wr_data
);
    import csem_pkg::*;

    t_slot_rec r_mem [SLOTS];
    t_slot_rec r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

### rtl/csem_wait_mem.sv
`default_nettype none

module csem_wait_mem (
    input  wire                          i_clk,
    input  wire                          i_rd_en,
    input  wire [csem_pkg::SLOT_W-1:0]   i_rd_slot,
    input  wire [csem_pkg::HEAD_W-1:0]   i_rd_pos,
    output logic [csem_pkg::PID_W-1:0]   o_rd_pid,
    input  wire                          i_wr_en,
    input  wire [csem_pkg::SLOT_W-1:0]   i_wr_slot,
    input  wire [csem_pkg::HEAD_W-1:0]   i_wr_pos,
    input  wire [csem_pkg::PID_W-1:0]    i_wr_pid
);
    import csem_pkg::*;

    // one circular queue of pids per slot
    logic [PID_W-1:0] r_mem [SLOTS][WAIT_DEPTH];
    logic [PID_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot][i_wr_pos] <= i_wr_pid;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_slot][i_rd_pos];
        end
    end

    assign o_rd_pid = r_rd;

endmodule

`default_nettype wire

### rtl/counting_semaphore_table_core.sv
// channel  | dir | handshake                       | payload
// s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready | tuser: cmd; tdata: slot, key, pid
// m_axis   | out | o_m_axis_tvalid/i_m_axis_tready | tuser: status; tdata: slot, count, pid
//
// one item at a time: accept, key match and slot lookup, slot memory read,
// update; the result is loaded in the update step, or, for a post that
// wakes a waiter, after a second read from the waiter memory once the queue head is known.
// a new item is taken in the cycle after the result is loaded, so no item is taken
// before the last one is through; a finished item holds while the result register is full.
// synchronous active-low reset clears the slot-used bits and the control state.
`default_nettype none
`include "counting_semaphore_table_core_macros.svh"

module counting_semaphore_table_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // sem_slot, name_key, caller_pid, zero pad
    input  wire [csem_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // cmd
    input  wire [csem_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // slot_out, count_out, woken_pid, zero pad
    output logic [csem_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [csem_pkg::ST_W-1:0]         o_m_axis_tuser
);
    import csem_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_WAKE} t_state;
    typedef enum logic [2:0] {K_HIT, K_CLAIM, K_TFULL, K_BAD, K_OP} t_kind;

    localparam int SUM_W = FILL_W + 1;

    t_state              r_state;
    t_kind               r_kind;
    t_cmd                r_cmd;
    logic [SEM_W-1:0]    r_sem;
    logic [KEY_BITS-1:0] r_name;
    logic [PID_W-1:0]    r_pid;
    logic [SLOTS-1:0]    r_match;
    logic [SLOTS-1:0]    r_free;
    logic                r_sok;
    logic [SLOT_W-1:0]   r_tgt;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [SEM_W-1:0]    r_out_slot;
    logic [CNT_W-1:0]    r_out_cnt;
    logic [PID_W-1:0]    r_out_pid;

    logic [SEM_W-1:0]    in_sem;
    logic [KEY_BITS-1:0] in_key;
    logic [SLOT_W-1:0]   in_idx;
    logic                accept;
    logic                out_free;
    logic                out_load;

    logic [SLOTS-1:0]    w_used;
    logic [SLOTS-1:0]    w_match;
    t_key_wr             key_wr;

    logic                lk_hit;
    logic [SLOT_W-1:0]   lk_hit_idx;
    logic                lk_free;
    logic [SLOT_W-1:0]   lk_free_idx;
    logic [SLOT_W-1:0]   lk_tgt;
    t_kind               lk_kind;

    t_slot_rec           w_rec;
    t_slot_rec           sm_wdata;
    logic                sm_we;
    logic [PID_W-1:0]    w_wpid;
    logic                wm_we;
    logic                wm_re;

    logic [SUM_W-1:0]    ex_sum;
    logic [HEAD_W-1:0]   ex_tail;
    logic [HEAD_W-1:0]   ex_next_head;
    logic                ex_wake;
    logic                ex_go;
    t_status             ex_status;
    logic [SEM_W-1:0]    ex_slot;
    logic [CNT_W-1:0]    ex_cnt;

    assign in_sem = i_s_axis_tdata[SEM_W-1:0];
    assign in_key = i_s_axis_tdata[SEM_W +: KEY_BITS];
    assign in_idx = SLOT_W'(in_sem);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    csem_key_table u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (key_wr),
        .i_key   (in_key),
        .o_used  (w_used),
        .o_match (w_match)
    );

    // lowest matching slot and lowest free slot
    always_comb begin
        lk_hit      = 1'b0;
        lk_hit_idx  = '0;
        lk_free     = 1'b0;
        lk_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                lk_hit     = 1'b1;
                lk_hit_idx = SLOT_W'(i);
            end
            if (r_free[i]) begin
                lk_free     = 1'b1;
                lk_free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (r_cmd == CMD_OPEN) begin
            if (lk_hit) begin
                lk_kind = K_HIT;
                lk_tgt  = lk_hit_idx;
            end else if (lk_free) begin
                lk_kind = K_CLAIM;
                lk_tgt  = lk_free_idx;
            end else begin
                lk_kind = K_TFULL;
                lk_tgt  = '0;
            end
        end else begin
            lk_kind = r_sok ? K_OP : K_BAD;
            lk_tgt  = SLOT_W'(r_sem);
        end
    end

    csem_slot_mem u_slots (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_LOOK),
        .i_rd_idx  (lk_tgt),
        .o_rd_data (w_rec),
        .i_wr_en   (sm_we),
        .i_wr_idx  (r_tgt),
        .i_wr_data (sm_wdata)
    );

    csem_wait_mem u_waiters (
        .i_clk     (i_clk),
        .i_rd_en   (wm_re),
        .i_rd_slot (r_tgt),
        .i_rd_pos  (w_rec.head),
        .o_rd_pid  (w_wpid),
        .i_wr_en   (wm_we),
        .i_wr_slot (r_tgt),
        .i_wr_pos  (ex_tail),
        .i_wr_pid  (r_pid)
    );

    // queue tail and next head, wrapping at the queue depth
    assign ex_sum  = SUM_W'(w_rec.head) + SUM_W'(w_rec.fill);
    assign ex_tail = (ex_sum >= SUM_W'(WAIT_DEPTH)) ? HEAD_W'(ex_sum - SUM_W'(WAIT_DEPTH))
                                                     : HEAD_W'(ex_sum);
    assign ex_next_head = (w_rec.head == HEAD_W'(WAIT_DEPTH - 1)) ? '0
                                                                  : w_rec.head + HEAD_W'(1);

    assign ex_wake = (r_kind == K_OP) && (r_cmd == CMD_POST) && (w_rec.fill != '0);
    assign ex_go   = (r_state == S_EXEC) && (ex_wake || out_free);
    assign wm_re   = ex_go && ex_wake;

    assign out_load = (ex_go && !ex_wake) || ((r_state == S_WAKE) && out_free);

    always_comb begin
        ex_status    = ST_OK;
        ex_slot      = r_sem;
        ex_cnt       = w_rec.count;
        sm_we        = 1'b0;
        sm_wdata     = w_rec;
        wm_we        = 1'b0;
        key_wr.we    = 1'b0;
        key_wr.idx   = r_tgt;
        key_wr.key   = r_name;
        case (r_kind)
            K_HIT: begin
                ex_slot = SEM_W'(r_tgt);
            end
            K_CLAIM: begin
                ex_slot        = SEM_W'(r_tgt);
                ex_cnt         = CNT_W'(1);
                sm_we          = ex_go;
                sm_wdata.count = CNT_W'(1);
                sm_wdata.head  = '0;
                sm_wdata.fill  = '0;
                key_wr.we      = ex_go;
            end
            K_TFULL: begin
                ex_status = ST_TFULL;
                ex_slot   = '0;
                ex_cnt    = '0;
            end
            K_BAD: begin
                ex_cnt = '0;
            end
            default: begin
                case (r_cmd)
                    CMD_WAIT: begin
                        if (w_rec.count != '0) begin
                            ex_cnt         = w_rec.count - CNT_W'(1);
                            sm_we          = ex_go;
                            sm_wdata.count = w_rec.count - CNT_W'(1);
                        end else if (w_rec.fill >= FILL_W'(WAIT_DEPTH)) begin
                            ex_status = ST_QFULL;
                        end else begin
                            ex_status     = ST_BLOCK;
                            sm_we         = ex_go;
                            sm_wdata.fill = w_rec.fill + FILL_W'(1);
                            wm_we         = ex_go;
                        end
                    end
                    CMD_POST: begin
                        if (ex_wake) begin
                            // direct handoff: value unchanged, oldest waiter leaves
                            ex_status     = ST_WOKEN;
                            sm_we         = ex_go;
                            sm_wdata.head = ex_next_head;
                            sm_wdata.fill = w_rec.fill - FILL_W'(1);
                        end else begin
                            if (w_rec.count != CNT_MAX) begin
                                ex_cnt         = w_rec.count + CNT_W'(1);
                                sm_wdata.count = w_rec.count + CNT_W'(1);
                            end
                            sm_we = ex_go;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_s_axis_tuser;
                        r_sem   <= in_sem;
                        r_name  <= in_key;
                        r_pid   <= i_s_axis_tdata[SEM_W + NAME_W +: PID_W];
                        r_match <= w_match;
                        r_free  <= ~w_used;
                        r_sok   <= (32'(in_sem) < SLOTS) && w_used[in_idx];
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_kind  <= lk_kind;
                    r_tgt   <= lk_tgt;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (ex_go) begin
                        if (ex_wake) begin
                            r_state <= S_WAKE;
                        end else begin
                            r_out_status <= ex_status;
                            r_out_slot   <= ex_slot;
                            r_out_cnt    <= ex_cnt;
                            r_out_pid    <= '0;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                S_WAKE: begin
                    if (out_free) begin
                        r_out_status <= ST_WOKEN;
                        r_out_slot   <= r_sem;
                        r_out_cnt    <= w_rec.count;
                        r_out_pid    <= w_wpid;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {(OUT_DATA_W - SEM_W - CNT_W - PID_W)'(0),
                              r_out_pid, r_out_cnt, r_out_slot};

    `CSEM_ASSERT_NXT(a_claim_marks_used, i_clk, i_rst_n,
        (r_state == S_EXEC) && (r_kind == K_CLAIM) && out_free,
        w_used[r_tgt], "claimed slot not marked used")
    `CSEM_ASSERT_IMP(a_fill_bounded, i_clk, i_rst_n,
        (r_state == S_EXEC) && (r_kind == K_OP),
        w_rec.fill <= FILL_W'(WAIT_DEPTH), "wait queue fill above depth")
    `CSEM_ASSERT_IMP(a_block_at_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_status == ST_BLOCK),
        r_out_cnt == '0, "caller blocked on nonzero value")
    `CSEM_ASSERT_IMP(a_result_source, i_clk, i_rst_n,
        $rose(r_out_valid),
        $past((r_state == S_EXEC) || (r_state == S_WAKE)), "result loaded outside update step")

endmodule

`default_nettype wire
